>>> rtl/core/fpa_pkg.sv
// Shared types, constants and opcodes for the Q24.8 fixed-point ALU.
// No dependencies; the core files that use it refer to it by scoped names.
`timescale 1ns / 1ps
package fpa_pkg;
   localparam int WORD_BITS_DEF     = 32;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int FUNC_BITS         = 4;
   localparam int QUEUE_DEPTH       = 4;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD      = 4'd0,
      FUNC_SUB      = 4'd1,
      FUNC_MUL      = 4'd2,
      FUNC_DIV      = 4'd3,
      FUNC_MIN      = 4'd4,
      FUNC_MAX      = 4'd5,
      FUNC_INC      = 4'd6,
      FUNC_DEC      = 4'd7,
      FUNC_TO_INT   = 4'd8,
      FUNC_FROM_INT = 4'd9
   } func_type;

   // result flags carried alongside the value
   typedef struct packed {
      logic less;
      logic equal;
      logic greater;
      logic divide_by_zero;
   } flags_type;
endpackage

>>> rtl/core/fpa_front.sv
// Front end: accepts operations, classifies them and computes the compare flags.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_front #(
   parameter int WORD_BITS = fpa_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [fpa_pkg::FUNC_BITS-1:0] in_func,
   input  logic signed [WORD_BITS-1:0]   in_a,
   input  logic signed [WORD_BITS-1:0]   in_b,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [fpa_pkg::FUNC_BITS-1:0] out_func,
   output logic signed [WORD_BITS-1:0]   out_a,
   output logic signed [WORD_BITS-1:0]   out_b,
   output fpa_pkg::flags_type            out_flags
);
   logic                          valid_ff, valid_in;
   logic [fpa_pkg::FUNC_BITS-1:0] func_ff;
   logic signed [WORD_BITS-1:0]   a_ff, b_ff;
   fpa_pkg::flags_type            flags_ff, flags_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // compare flags and divide-by-zero classification
   always_comb begin
      flags_in.less           = in_a < in_b;
      flags_in.equal          = in_a == in_b;
      flags_in.greater        = in_a > in_b;
      flags_in.divide_by_zero = (in_func == fpa_pkg::FUNC_DIV) && (in_b == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         func_ff  <= in_func;
         a_ff     <= in_a;
         b_ff     <= in_b;
         flags_ff <= flags_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_func  = func_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_flags = flags_ff;
endmodule

>>> rtl/core/fpa_queue.sv
// Small FIFO that decouples the front end from the execution pipeline.
// Depends on fpa_pkg.
`timescale 1ns / 1ps
module fpa_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = fpa_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DATA_BITS-1:0] out_data
);
   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [DATA_BITS-1:0] slot_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_BITS:0]    count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != PTR_BITS'(0) + (PTR_BITS+1)'(DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? ((wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in    = pop  ? ((rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      count_in = count_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= in_data;
      end
   end
endmodule

>>> rtl/core/fpa_div.sv
// Pipelined radix-2 restoring divider on magnitudes, one quotient bit per stage.
// No dependencies.
`timescale 1ns / 1ps
module fpa_div #(
   parameter int NUM_BITS  = 40,
   parameter int DEN_BITS  = 32,
   parameter int TAG_BITS  = 8
) (
   input  logic                clock,
   input  logic                advance,
   input  logic [NUM_BITS-1:0] in_num,
   input  logic [DEN_BITS-1:0] in_den,
   input  logic [TAG_BITS-1:0] in_tag,
   output logic [NUM_BITS-1:0] out_quot,
   output logic [TAG_BITS-1:0] out_tag
);
   // stage s holds partial remainder, remaining dividend bits, divisor, tag
   logic [DEN_BITS-1:0] rem_ff [1:NUM_BITS];
   logic [NUM_BITS-1:0] num_ff [1:NUM_BITS];
   logic [DEN_BITS-1:0] den_ff [1:NUM_BITS];
   logic [TAG_BITS-1:0] tag_ff [1:NUM_BITS];

   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      logic [DEN_BITS-1:0] rem_cur;
      logic [NUM_BITS-1:0] num_cur;
      logic [DEN_BITS-1:0] den_cur;
      logic [TAG_BITS-1:0] tag_cur;
      logic [DEN_BITS+1:0] trial;
      logic [DEN_BITS:0]   shifted;

      // first stage starts from the inputs with a zero remainder
      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign num_cur = in_num;
         assign den_cur = in_den;
         assign tag_cur = in_tag;
      end else begin : g_next
         assign rem_cur = rem_ff[s];
         assign num_cur = num_ff[s];
         assign den_cur = den_ff[s];
         assign tag_cur = tag_ff[s];
      end

      assign shifted = {rem_cur, num_cur[NUM_BITS-1]};
      assign trial   = {1'b0, shifted} - {2'b00, den_cur};
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s+1] <= trial[DEN_BITS+1] ? shifted[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            num_ff[s+1] <= {num_cur[NUM_BITS-2:0], !trial[DEN_BITS+1]};
            den_ff[s+1] <= den_cur;
            tag_ff[s+1] <= tag_cur;
         end
      end
   end

   assign out_quot = num_ff[NUM_BITS];
   assign out_tag  = tag_ff[NUM_BITS];
endmodule

>>> rtl/core/fpa_back.sv
// Execution pipeline: all operations travel the divider's depth in lockstep.
// Depends on fpa_pkg and fpa_div.
`timescale 1ns / 1ps
module fpa_back #(
   parameter int WORD_BITS     = fpa_pkg::WORD_BITS_DEF,
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [fpa_pkg::FUNC_BITS-1:0] in_func,
   input  logic signed [WORD_BITS-1:0]   in_a,
   input  logic signed [WORD_BITS-1:0]   in_b,
   input  fpa_pkg::flags_type            in_flags,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [WORD_BITS-1:0]   out_value,
   output fpa_pkg::flags_type            out_flags
);
   localparam int NUM_BITS = WORD_BITS + FRACTION_BITS;
   localparam int PROD_BITS = 2 * WORD_BITS;
   // tag: is_div, negate, flags, precomputed value
   localparam int TAG_BITS = 2 + 4 + WORD_BITS;
   localparam int LAT = NUM_BITS;

   logic                          advance;
   logic [LAT-1:0]                vld_ff;
   logic signed [WORD_BITS-1:0]   value_in;
   logic [WORD_BITS-1:0]          mag_a, mag_b;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                          is_mul_ff;
   logic [TAG_BITS-1:0]           tag_in, tag_out;
   logic [NUM_BITS-1:0]           quot;
   logic [WORD_BITS-1:0]          qword;
   logic                          res_valid_ff;
   logic signed [WORD_BITS-1:0]   res_value_ff, res_value_in, mid_value;
   fpa_pkg::flags_type            res_flags_ff, mid_flags;
   logic                          t_div, t_neg;

   // pipeline moves when the result register is free or being drained
   assign advance  = !res_valid_ff || out_ready;
   assign in_ready = advance;

   // simple operations computed at entry
   always_comb begin
      case (in_func)
         fpa_pkg::FUNC_ADD:      value_in = in_a + in_b;
         fpa_pkg::FUNC_SUB:      value_in = in_a - in_b;
         fpa_pkg::FUNC_MIN:      value_in = in_flags.less ? in_a : in_b;
         fpa_pkg::FUNC_MAX:      value_in = in_flags.greater ? in_a : in_b;
         fpa_pkg::FUNC_INC:      value_in = in_a + WORD_BITS'(1);
         fpa_pkg::FUNC_DEC:      value_in = in_a - WORD_BITS'(1);
         fpa_pkg::FUNC_TO_INT:   value_in = in_a >>> FRACTION_BITS;
         fpa_pkg::FUNC_FROM_INT: value_in = in_a <<< FRACTION_BITS;
         default:                value_in = '0;
      endcase
      mag_a  = in_a[WORD_BITS-1] ? WORD_BITS'(-in_a) : in_a;
      mag_b  = in_b[WORD_BITS-1] ? WORD_BITS'(-in_b) : in_b;
      tag_in = {(in_func == fpa_pkg::FUNC_DIV) && !in_flags.divide_by_zero,
                in_a[WORD_BITS-1] ^ in_b[WORD_BITS-1], in_flags, value_in};
      prod_in = PROD_BITS'(in_a) * PROD_BITS'(in_b);
   end

   // product registered one stage after entry, merged at the end
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff   <= prod_in;
         is_mul_ff <= in_func == fpa_pkg::FUNC_MUL;
      end
   end

   fpa_div #(
      .NUM_BITS (NUM_BITS),
      .DEN_BITS (WORD_BITS),
      .TAG_BITS (TAG_BITS)
   ) u_div (
      .clock    (clock),
      .advance  (advance),
      .in_num   ({mag_a, FRACTION_BITS'(0)}),
      .in_den   (mag_b),
      .in_tag   (tag_in),
      .out_quot (quot),
      .out_tag  (tag_out)
   );

   // carry the multiply result so that it leaves together with the divider tag
   logic signed [WORD_BITS-1:0] mul_ff [LAT-1];
   logic                        mulv_ff [LAT-1];
   always_ff @(posedge clock) begin
      if (advance) begin
         mul_ff[0]  <= WORD_BITS'(prod_ff >>> FRACTION_BITS);
         mulv_ff[0] <= is_mul_ff;
         for (int i = 1; i < LAT - 1; i++) begin
            mul_ff[i]  <= mul_ff[i-1];
            mulv_ff[i] <= mulv_ff[i-1];
         end
      end
   end

   assign t_div     = tag_out[TAG_BITS-1];
   assign t_neg     = tag_out[TAG_BITS-2];
   assign mid_flags = tag_out[WORD_BITS+3:WORD_BITS];
   assign qword     = quot[WORD_BITS-1:0];
   assign mid_value = tag_out[WORD_BITS-1:0];

   always_comb begin
      if (mulv_ff[LAT-2]) begin
         res_value_in = mul_ff[LAT-2];
      end else if (t_div) begin
         res_value_in = t_neg ? WORD_BITS'(-qword) : qword;
      end else begin
         res_value_in = mid_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         res_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[LAT-2:0], in_valid};
         res_valid_ff <= vld_ff[LAT-1];
      end
      if (advance) begin
         res_value_ff <= res_value_in;
         res_flags_ff <= mid_flags;
      end
   end

   assign out_valid = res_valid_ff;
   assign out_value = res_value_ff;
   assign out_flags = res_flags_ff;
endmodule

>>> rtl/core/fixed_point_q24_8_alu.sv
// Top level of the Q24.8 fixed-point ALU: front end, queue, execution pipeline.
// Depends on fpa_pkg, fpa_front, fpa_queue, fpa_back.
`timescale 1ns / 1ps
// One transaction in, one transaction out, at one per clock sustained while
// rsp_tready stays high. Every operation has the same latency and passes, from
// request to response, through the front end register, the queue, the stages of
// the pipelined restoring divider and then the result register; results leave in
// order. A four-entry queue between the front end and the pipeline absorbs
// back-pressure. Division by zero returns 0 with divide_by_zero set; all other
// results wrap to the word.
module fixed_point_q24_8_alu #(
   parameter int WORD_BITS     = fpa_pkg::WORD_BITS_DEF,
   parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // {operand_b, operand_a, func} from bit 0: func[3:0], operand_a, operand_b, zero pad
   input  logic [((fpa_pkg::FUNC_BITS+2*WORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // from bit 0: value, less, equal, greater, divide_by_zero, zero pad
   output logic [((WORD_BITS+4+7)/8)*8-1:0] rsp_tdata
);
   localparam int REQ_BITS = ((fpa_pkg::FUNC_BITS + 2 * WORD_BITS + 7) / 8) * 8;
   localparam int RSP_BITS = ((WORD_BITS + 4 + 7) / 8) * 8;
   localparam int Q_BITS   = fpa_pkg::FUNC_BITS + 2 * WORD_BITS + 4;

   logic                          f_valid, f_ready, b_valid, b_ready;
   logic [fpa_pkg::FUNC_BITS-1:0] f_func, b_func;
   logic signed [WORD_BITS-1:0]   f_a, f_b, b_a, b_b, r_value;
   fpa_pkg::flags_type            f_flags, b_flags, r_flags;
   logic [Q_BITS-1:0]             q_out;

   fpa_front #(.WORD_BITS(WORD_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tdata[fpa_pkg::FUNC_BITS-1:0]),
      .in_a      (req_tdata[fpa_pkg::FUNC_BITS +: WORD_BITS]),
      .in_b      (req_tdata[fpa_pkg::FUNC_BITS+WORD_BITS +: WORD_BITS]),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_func  (f_func),
      .out_a     (f_a),
      .out_b     (f_b),
      .out_flags (f_flags)
   );

   fpa_queue #(.DATA_BITS(Q_BITS), .DEPTH(fpa_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_flags, f_b, f_a, f_func}),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (q_out)
   );

   assign {b_flags, b_b, b_a, b_func} = q_out;

   fpa_back #(.WORD_BITS(WORD_BITS), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_func   (b_func),
      .in_a      (b_a),
      .in_b      (b_b),
      .in_flags  (b_flags),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (r_value),
      .out_flags (r_flags)
   );

   assign rsp_tdata = RSP_BITS'({r_flags.divide_by_zero, r_flags.greater,
                                 r_flags.equal, r_flags.less, r_value});
endmodule

>>> rtl/core/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
// Depends on fixed_point_q24_8_alu.
`timescale 1ns / 1ps
module fpa_checker #(
   parameter int RSP_BITS = 40
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata
);
   // compare flags are mutually exclusive
   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot({rsp_tdata[32], rsp_tdata[33], rsp_tdata[34]}))
      else $error("compare flags not one-hot");

   // divide by zero always returns zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[31:0] == '0)
      else $error("divide by zero value not zero");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
endmodule

bind fixed_point_q24_8_alu fpa_checker #(.RSP_BITS(40)) u_fpa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/fixed_point_q24_8_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU: directed and random operations,
// in-order result checking against a behavioral predictor, random idling on both sides.
// Depends on fpa_pkg and fixed_point_q24_8_alu.
`timescale 1ns / 1ps
module fixed_point_q24_8_alu_tb;
   localparam int REQ_W = ((fpa_pkg::FUNC_BITS + 64 + 7) / 8) * 8;
   localparam int RSP_W = ((32 + 4 + 7) / 8) * 8;
   localparam int N_RANDOM = 700;
   localparam int TAIL_ITEMS = 120;
   localparam longint CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [3:0]  func;
      logic [31:0] a;
      logic [31:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] value;
      logic less, equal, greater, dz;
   } alu_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // from bit 0: func[3:0], operand_a, operand_b, zero pad
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // from bit 0: value, less, equal, greater, divide_by_zero, zero pad
   logic [RSP_W-1:0] rsp_tdata;

   alu_op_type  pending_ops[$];
   alu_res_type expected_results[$];
   int       errors = 0;
   int       sent = 0;
   bit       stim_done = 0;
   bit       quiet = 0;     // no idling in the last part of the run
   int       hold_off = 0;  // long receiver stall
   int       tx_gap = 0;
   int       rx_gap = 0;
   longint   cycles = 0;

   fixed_point_q24_8_alu dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor of one ALU result
   function automatic alu_res_type alu_compute(alu_op_type op);
      alu_res_type r;
      logic signed [31:0] sa, sb;
      logic signed [63:0] prod;
      logic [63:0] ma, mb, q;
      sa = op.a;
      sb = op.b;
      r = '0;
      r.less = sa < sb;
      r.equal = op.a == op.b;
      r.greater = sa > sb;
      case (op.func)
         fpa_pkg::FUNC_ADD: r.value = op.a + op.b;
         fpa_pkg::FUNC_SUB: r.value = op.a - op.b;
         fpa_pkg::FUNC_MUL: begin
            prod = 64'(sa) * 64'(sb);
            r.value = 32'(prod >>> fpa_pkg::FRACTION_BITS_DEF);
         end
         fpa_pkg::FUNC_DIV: begin
            if (op.b == '0) begin
               r.value = '0;
               r.dz = 1'b1;
            end else begin
               ma = sa[31] ? 64'(-64'(sa)) : 64'(sa);
               mb = sb[31] ? 64'(-64'(sb)) : 64'(sb);
               q = (ma << fpa_pkg::FRACTION_BITS_DEF) / mb;
               if (sa[31] != sb[31]) q = -q;
               r.value = q[31:0];
            end
         end
         fpa_pkg::FUNC_MIN: r.value = (sa < sb) ? op.a : op.b;
         fpa_pkg::FUNC_MAX: r.value = (sa > sb) ? op.a : op.b;
         fpa_pkg::FUNC_INC: r.value = op.a + 32'd1;
         fpa_pkg::FUNC_DEC: r.value = op.a - 32'd1;
         fpa_pkg::FUNC_TO_INT: r.value = sa >>> fpa_pkg::FRACTION_BITS_DEF;
         fpa_pkg::FUNC_FROM_INT: r.value = op.a << fpa_pkg::FRACTION_BITS_DEF;
         default: r.value = '0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($urandom_range(0, 4)) - 32'd2;
         3: return 32'($urandom_range(0, 2047)) - 32'd1024;
         4: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
         default: return $urandom;
      endcase
   endfunction

   task automatic add_op(logic [3:0] f, logic [31:0] a, logic [31:0] b);
      alu_op_type op;
      op.func = f;
      op.a = a;
      op.b = b;
      pending_ops.push_back(op);
   endtask

   // stimulus
   initial begin
      alu_op_type op;
      add_op(fpa_pkg::FUNC_ADD, 32'h7FFF_FFFF, 32'h0000_0001);
      add_op(fpa_pkg::FUNC_SUB, 32'h8000_0000, 32'h0000_0001);
      add_op(fpa_pkg::FUNC_MUL, 32'h8000_0000, 32'h8000_0000);
      add_op(fpa_pkg::FUNC_MUL, 32'hFFFF_FF00, 32'h0000_0180);
      add_op(fpa_pkg::FUNC_DIV, 32'h0000_0100, 32'h0000_0000);
      add_op(fpa_pkg::FUNC_DIV, 32'h8000_0000, 32'hFFFF_FF00);
      add_op(fpa_pkg::FUNC_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      add_op(fpa_pkg::FUNC_DIV, 32'hFFFF_FD00, 32'h0000_0200);
      add_op(fpa_pkg::FUNC_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
      add_op(fpa_pkg::FUNC_MIN, 32'h0000_0500, 32'h0000_0500);
      add_op(fpa_pkg::FUNC_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      add_op(fpa_pkg::FUNC_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
      add_op(fpa_pkg::FUNC_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_op(fpa_pkg::FUNC_DEC, 32'h8000_0000, 32'h0000_0000);
      add_op(fpa_pkg::FUNC_TO_INT, 32'hFFFF_FF01, 32'h0000_0000);
      add_op(fpa_pkg::FUNC_TO_INT, 32'h7FFF_FFFF, 32'h0000_0000);
      add_op(fpa_pkg::FUNC_FROM_INT, 32'h00FF_FFFF, 32'h0000_0000);
      add_op(fpa_pkg::FUNC_FROM_INT, 32'hFF80_0000, 32'h0000_0000);
      add_op(4'd10, 32'h0000_0001, 32'h0000_0002);
      add_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      for (int i = 0; i < N_RANDOM; i++) begin
         op.func = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
         op.a = rand_operand();
         op.b = ($urandom_range(0, 9) == 0) ? op.a : rand_operand();
         if (op.func == fpa_pkg::FUNC_DIV && $urandom_range(0, 9) == 0) op.b = '0;
         pending_ops.push_back(op);
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) sent++;
         if (pending_ops.size() > TAIL_ITEMS && !quiet) quiet = 0; else quiet = 1;
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            tx_gap = $urandom_range(0, 3);
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            req_tdata <= REQ_W'({pending_ops[0].b, pending_ops[0].a, pending_ops[0].func});
            expected_results.push_back(alu_compute(pending_ops[0]));
            void'(pending_ops.pop_front());
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
            stim_done = 1;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (sent >= 200 && hold_off == 0) begin
         hold_off = 150;
         rsp_tready <= 1'b0;
      end else if (hold_off > 1) begin
         hold_off--;
         rsp_tready <= 1'b0;
      end else if (hold_off == 1) begin
         hold_off = -1;
         rsp_tready <= 1'b1;
      end else if (rx_gap > 0) begin
         rx_gap--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rx_gap = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      alu_res_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[33], rsp_tdata[34], rsp_tdata[35]};
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transaction, actual %h", $realtime, got);
            errors++;
         end else begin
            want = expected_results.pop_front();
            if (got.value !== want.value) begin
               $display("%0t: value expected %h actual %h", $realtime, want.value, got.value);
               errors++;
            end
            if (got.less !== want.less) begin
               $display("%0t: less expected %b actual %b", $realtime, want.less, got.less);
               errors++;
            end
            if (got.equal !== want.equal) begin
               $display("%0t: equal expected %b actual %b", $realtime, want.equal, got.equal);
               errors++;
            end
            if (got.greater !== want.greater) begin
               $display("%0t: greater expected %b actual %b", $realtime, want.greater,
                        got.greater);
               errors++;
            end
            if (got.dz !== want.dz) begin
               $display("%0t: divide_by_zero expected %b actual %b", $realtime, want.dz,
                        got.dz);
               errors++;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // reset and end of run
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && expected_results.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule

>>> sim.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_front.sv
rtl/core/fpa_queue.sv
rtl/core/fpa_div.sv
rtl/core/fpa_back.sv
rtl/core/fixed_point_q24_8_alu.sv
rtl/core/fpa_checker.sv
tb/fixed_point_q24_8_alu_tb.sv
